// ===== sv/spof_pkg.sv =====
// ----------------------------------------------------------------------------
// spof_pkg
// Shared constants and codes for the suffix-prefix overlap finder.
// ----------------------------------------------------------------------------
`default_nettype none

package spof_pkg;

	localparam int DEF_MAX_LEN = 256;

	localparam int FUNC_W     = 2;
	localparam int BASE_W     = 8;
	localparam int MARK_W     = 9;
	localparam int SUP_W      = 16;
	localparam int CHROM_W    = 16;
	localparam int OFS_W      = 16;
	localparam int OLEN_W     = 9;
	localparam int MINSUP_W   = 17;
	localparam int MINOV_W    = 9;
	localparam int RATE_W     = 17;
	localparam int RATE_FRAC  = 16;

	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;
	localparam int REG_IDX_W  = 2;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_FIRST  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_SECOND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RUN         = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_MIN_SUPPORT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MIN_OVERLAP   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MISMATCH_RATE = 2'd2;

	localparam logic [OFS_W-1:0] OFS_MAX = 16'h7FFF;

endpackage

`default_nettype wire

// ===== sv/spof_ram.sv =====
// ----------------------------------------------------------------------------
// spof_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spof_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/suffix_prefix_overlap_finder.sv =====
// Load words are taken back to back; in_ready stays high while idle.
// A run word keeps in_ready low through the search: the shift bounds may end it, each
// shift below min_overlap is skipped, any other goes through shift, multiply, len reads,
// drain and verdict, through one store read port each and one mismatch counter.
// The result word waits in an output register; loads are taken meanwhile, a finished run holds.
// arst_n clears lengths, registers, sequencer and output valid; stores are not cleared.
// ----------------------------------------------------------------------------
// suffix_prefix_overlap_finder
// Loads two base sequences and searches the first suffix-prefix overlap of
// the proximal sequence onto the distal one within a mismatch budget.
// ----------------------------------------------------------------------------
`default_nettype none

module suffix_prefix_overlap_finder #(
	parameter int MAX_LEN = spof_pkg::DEF_MAX_LEN
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [spof_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [spof_pkg::PDATA_W-1:0]      pwdata,
	output logic      [spof_pkg::PDATA_W-1:0]      prdata,
	output logic                                   pready,

	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [spof_pkg::FUNC_W-1:0]       func,
	input  wire logic [spof_pkg::BASE_W-1:0]       base,
	input  wire logic [spof_pkg::MARK_W-1:0]       first_marker,
	input  wire logic [spof_pkg::MARK_W-1:0]       second_marker,
	input  wire logic [spof_pkg::SUP_W-1:0]        first_support,
	input  wire logic [spof_pkg::SUP_W-1:0]        second_support,
	input  wire logic [spof_pkg::CHROM_W-1:0]      first_chrom,
	input  wire logic [spof_pkg::CHROM_W-1:0]      second_chrom,
	input  wire logic                              first_is_proximal,
	input  wire logic signed [spof_pkg::OFS_W-1:0] offset_in,

	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [spof_pkg::OLEN_W-1:0]       overlap_len,
	output logic signed [spof_pkg::OFS_W-1:0]      offset_out
);

	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int AW     = $clog2(MAX_LEN);
	localparam int MW     = spof_pkg::MARK_W + 1;
	localparam int W      = ((LEN_W > spof_pkg::MARK_W) ? LEN_W : spof_pkg::MARK_W) + 2;
	localparam int PROD_W = spof_pkg::RATE_W + LEN_W;
	localparam int ALW_W  = PROD_W + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHIFT = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_CMP   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;

	logic [spof_pkg::MINSUP_W-1:0] min_support_q;
	logic [spof_pkg::MINOV_W-1:0]  min_overlap_q;
	logic [spof_pkg::RATE_W-1:0]   mismatch_rate_q;

	logic [LEN_W-1:0] first_len_q;
	logic [LEN_W-1:0] second_len_q;

	logic                           first_prox_q;
	logic [LEN_W-1:0]               lp_q;
	logic [LEN_W-1:0]               ld_q;
	logic [spof_pkg::MARK_W-1:0]    mp_q;
	logic [MW-1:0]                  m_q;
	logic [LEN_W-1:0]               len_q;
	logic [LEN_W-1:0]               start_q;
	logic [LEN_W-1:0]               idx_q;
	logic [LEN_W-1:0]               diff_q;
	logic [PROD_W-1:0]              prod_q;
	logic [LEN_W-1:0]               res_len_q;
	logic signed [spof_pkg::OFS_W-1:0] ofs_q;
	logic                           rd_vld_s1;

	logic                           out_valid_q;
	logic [spof_pkg::OLEN_W-1:0]    overlap_len_q;
	logic signed [spof_pkg::OFS_W-1:0] offset_out_q;

	logic in_acc;
	logic cfg_wr;
	logic run_ok;
	logic [spof_pkg::MINSUP_W-1:0] sup_sum;

	logic [W-1:0] m_w, lp_w, ld_w, mp_w, sum_w, len_w, start_w;
	logic         shift_ok;

	logic [AW-1:0]     prox_addr, dist_addr;
	logic [LEN_W:0]    prox_sum;
	logic [AW-1:0]     first_raddr, second_raddr;
	logic [spof_pkg::BASE_W-1:0] first_rdata, second_rdata;
	logic              first_we, second_we;
	logic              mismatch;
	logic              issue;
	logic [ALW_W-1:0]  allowed;
	logic              pass;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_support_q   <= '0;
			min_overlap_q   <= '0;
			mismatch_rate_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				spof_pkg::REG_MIN_SUPPORT:
					min_support_q <= pwdata[spof_pkg::MINSUP_W-1:0];
				spof_pkg::REG_MIN_OVERLAP:
					min_overlap_q <= pwdata[spof_pkg::MINOV_W-1:0];
				spof_pkg::REG_MISMATCH_RATE:
					mismatch_rate_q <= pwdata[spof_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			spof_pkg::REG_MIN_SUPPORT:
				prdata = spof_pkg::PDATA_W'(min_support_q);
			spof_pkg::REG_MIN_OVERLAP:
				prdata = spof_pkg::PDATA_W'(min_overlap_q);
			spof_pkg::REG_MISMATCH_RATE:
				prdata = spof_pkg::PDATA_W'(mismatch_rate_q);
			default:
				prdata = '0;
		endcase
	end

	// input side
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;

	assign sup_sum = spof_pkg::MINSUP_W'(first_support) + spof_pkg::MINSUP_W'(second_support);
	assign run_ok  = (first_chrom == second_chrom) && (sup_sum >= min_support_q);

	assign first_we  = in_acc && (func == spof_pkg::FUNC_LOAD_FIRST)
		&& (first_len_q < LEN_W'(MAX_LEN));
	assign second_we = in_acc && (func == spof_pkg::FUNC_LOAD_SECOND)
		&& (second_len_q < LEN_W'(MAX_LEN));

	// shift bounds
	assign m_w     = W'(m_q);
	assign lp_w    = W'(lp_q);
	assign ld_w    = W'(ld_q);
	assign mp_w    = W'(mp_q);
	assign sum_w   = m_w + lp_w;
	assign len_w   = sum_w - mp_w;
	assign start_w = mp_w - m_w;
	assign shift_ok = (m_w <= mp_w) && (sum_w >= mp_w) && (len_w <= ld_w);

	// store reads
	assign issue     = (state_q == ST_CMP) && (idx_q < len_q);
	assign prox_sum  = (LEN_W + 1)'(start_q) + (LEN_W + 1)'(idx_q);
	assign prox_addr = prox_sum[AW-1:0];
	assign dist_addr = idx_q[AW-1:0];
	assign first_raddr  = first_prox_q ? prox_addr : dist_addr;
	assign second_raddr = first_prox_q ? dist_addr : prox_addr;
	assign mismatch     = (first_rdata != second_rdata);

	assign allowed = (ALW_W'(prod_q) + ALW_W'((1 << spof_pkg::RATE_FRAC) - 1))
		>> spof_pkg::RATE_FRAC;
	assign pass    = (ALW_W'(diff_q) <= allowed);

	spof_ram #(
		.WIDTH(spof_pkg::BASE_W),
		.DEPTH(MAX_LEN)
	) u_first_ram (
		.clk  (clk),
		.we   (first_we),
		.waddr(first_len_q[AW-1:0]),
		.wdata(base),
		.raddr(first_raddr),
		.rdata(first_rdata)
	);

	spof_ram #(
		.WIDTH(spof_pkg::BASE_W),
		.DEPTH(MAX_LEN)
	) u_second_ram (
		.clk  (clk),
		.we   (second_we),
		.waddr(second_len_q[AW-1:0]),
		.wdata(base),
		.raddr(second_raddr),
		.rdata(second_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			first_len_q  <= '0;
			second_len_q <= '0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (first_we) begin
						first_len_q <= first_len_q + LEN_W'(1);
					end
					if (second_we) begin
						second_len_q <= second_len_q + LEN_W'(1);
					end
					if (in_acc && (func == spof_pkg::FUNC_RUN)) begin
						first_len_q  <= '0;
						second_len_q <= '0;
						state_q      <= run_ok ? ST_SHIFT : ST_DONE;
					end
				end
				ST_SHIFT: begin
					if (!shift_ok) begin
						state_q <= ST_DONE;
					end else if (len_w < W'(min_overlap_q)) begin
						state_q <= ST_SHIFT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!issue && !rd_vld_s1) begin
						state_q <= pass ? ST_DONE : ST_SHIFT;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				first_prox_q <= first_is_proximal;
				lp_q      <= first_is_proximal ? first_len_q : second_len_q;
				ld_q      <= first_is_proximal ? second_len_q : first_len_q;
				mp_q      <= first_is_proximal ? first_marker : second_marker;
				m_q       <= MW'(first_is_proximal ? second_marker : first_marker);
				ofs_q     <= offset_in;
				res_len_q <= '0;
			end
			ST_SHIFT: begin
				if (shift_ok) begin
					if (len_w < W'(min_overlap_q)) begin
						m_q <= m_q + MW'(1);
						if (ofs_q != spof_pkg::OFS_MAX) begin
							ofs_q <= ofs_q + spof_pkg::OFS_W'(1);
						end
					end
					len_q   <= len_w[LEN_W-1:0];
					start_q <= start_w[LEN_W-1:0];
				end
				idx_q  <= '0;
				diff_q <= '0;
			end
			ST_MUL: begin
				prod_q <= PROD_W'(mismatch_rate_q) * PROD_W'(len_q);
			end
			ST_CMP: begin
				if (issue) begin
					idx_q <= idx_q + LEN_W'(1);
				end
				if (rd_vld_s1 && mismatch) begin
					diff_q <= diff_q + LEN_W'(1);
				end
				if (!issue && !rd_vld_s1) begin
					if (pass) begin
						res_len_q <= len_q;
					end else begin
						m_q <= m_q + MW'(1);
						if (ofs_q != spof_pkg::OFS_MAX) begin
							ofs_q <= ofs_q + spof_pkg::OFS_W'(1);
						end
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					overlap_len_q <= spof_pkg::OLEN_W'(res_len_q);
					offset_out_q  <= ofs_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign overlap_len = overlap_len_q;
	assign offset_out  = offset_out_q;

endmodule

`default_nettype wire

// ===== sv/spof_check.sv =====
// ----------------------------------------------------------------------------
// spof_check
// Port-level checks of the overlap finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spof_check (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic [spof_pkg::FUNC_W-1:0]       func,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [spof_pkg::OLEN_W-1:0]       overlap_len,
	input wire logic signed [spof_pkg::OFS_W-1:0] offset_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(overlap_len) && $stable(offset_out))
		else $error("result word changed while stalled");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func != spof_pkg::FUNC_RUN) |=> !$rose(out_valid))
		else $error("result word raised by a load");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == spof_pkg::FUNC_RUN) |=> !in_ready)
		else $error("input taken right after a run word");

endmodule

bind suffix_prefix_overlap_finder spof_check u_spof_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.func       (func),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.overlap_len(overlap_len),
	.offset_out (offset_out)
);

`default_nettype wire

// ===== test/tb_suffix_prefix_overlap_finder.sv =====
// ----------------------------------------------------------------------------
// tb_suffix_prefix_overlap_finder
// Loads base sequences, runs overlap searches and checks every result word
// against a cycle-free predictor of the search. The register port moves
// between phases. Both channels idle and stall at random, with one long
// output hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_suffix_prefix_overlap_finder;

	localparam int SEQ_MAX   = spof_pkg::DEF_MAX_LEN;
	localparam int SETTLE    = 8;
	localparam int LONG_HOLD = 400;
	localparam int RUN_LIMIT = 2_000_000;
	localparam logic [spof_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [spof_pkg::FUNC_W-1:0]       func;
		logic [spof_pkg::BASE_W-1:0]       base;
		logic [spof_pkg::MARK_W-1:0]       first_marker;
		logic [spof_pkg::MARK_W-1:0]       second_marker;
		logic [spof_pkg::SUP_W-1:0]        first_support;
		logic [spof_pkg::SUP_W-1:0]        second_support;
		logic [spof_pkg::CHROM_W-1:0]      first_chrom;
		logic [spof_pkg::CHROM_W-1:0]      second_chrom;
		logic                              first_is_proximal;
		logic signed [spof_pkg::OFS_W-1:0] offset_in;
	} seq_word_t;

	typedef struct packed {
		logic [spof_pkg::OLEN_W-1:0]       len;
		logic signed [spof_pkg::OFS_W-1:0] ofs;
	} overlap_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [spof_pkg::PADDR_W-1:0] paddr;
	logic [spof_pkg::PDATA_W-1:0] pwdata;
	logic [spof_pkg::PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid, in_ready;
	logic [spof_pkg::FUNC_W-1:0] func;
	logic [spof_pkg::BASE_W-1:0] base;
	logic [spof_pkg::MARK_W-1:0] first_marker, second_marker;
	logic [spof_pkg::SUP_W-1:0] first_support, second_support;
	logic [spof_pkg::CHROM_W-1:0] first_chrom, second_chrom;
	logic first_is_proximal;
	logic signed [spof_pkg::OFS_W-1:0] offset_in;
	logic out_valid, out_ready;
	logic [spof_pkg::OLEN_W-1:0] overlap_len;
	logic signed [spof_pkg::OFS_W-1:0] offset_out;

	suffix_prefix_overlap_finder u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .func(func), .base(base),
		.first_marker(first_marker), .second_marker(second_marker),
		.first_support(first_support), .second_support(second_support),
		.first_chrom(first_chrom), .second_chrom(second_chrom),
		.first_is_proximal(first_is_proximal), .offset_in(offset_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.overlap_len(overlap_len), .offset_out(offset_out)
	);

	logic [spof_pkg::BASE_W-1:0] first_bases [SEQ_MAX];
	logic [spof_pkg::BASE_W-1:0] second_bases [SEQ_MAX];
	int first_count, second_count;
	int cfg_min_support, cfg_min_overlap, cfg_rate;
	overlap_t overlap_q[$];

	int fail_count, words_sent, load_words, run_words, hit_runs, settings_used;
	int burst_left;
	bit gaps_on;
	int hold_asked, hold_served;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#RUN_LIMIT;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [spof_pkg::BASE_W-1:0] stored_base(bit from_first, int idx);
		return from_first ? first_bases[idx] : second_bases[idx];
	endfunction

	function automatic overlap_t search_overlap(seq_word_t w);
		overlap_t r;
		int lp, ld, mp, md, m, len, diff, ofs;
		longint allowed;
		bit prox_first;
		prox_first = w.first_is_proximal;
		ofs = int'($signed(w.offset_in));
		r.len = '0;
		if (w.first_chrom == w.second_chrom &&
		    int'(w.first_support) + int'(w.second_support) >= cfg_min_support) begin
			lp = prox_first ? first_count : second_count;
			ld = prox_first ? second_count : first_count;
			mp = prox_first ? int'(w.first_marker) : int'(w.second_marker);
			md = prox_first ? int'(w.second_marker) : int'(w.first_marker);
			m = md;
			while (m <= mp && m + lp >= mp && m + lp - mp <= ld) begin
				len = m + lp - mp;
				if (len >= cfg_min_overlap) begin
					allowed = (longint'(cfg_rate) * len + 65535) >>> spof_pkg::RATE_FRAC;
					diff = 0;
					for (int i = 0; i < len; i++)
						if (stored_base(prox_first, mp - m + i) != stored_base(!prox_first, i))
							diff++;
					if (diff <= allowed) begin
						r.len = len[spof_pkg::OLEN_W-1:0];
						break;
					end
				end
				m++;
				if (ofs < int'(spof_pkg::OFS_MAX))
					ofs++;
			end
		end
		r.ofs = ofs[spof_pkg::OFS_W-1:0];
		return r;
	endfunction

	task automatic track_word(seq_word_t w);
		overlap_t res;
		case (w.func)
			spof_pkg::FUNC_LOAD_FIRST: begin
				if (first_count < SEQ_MAX) begin
					first_bases[first_count] = w.base;
					first_count++;
				end
				load_words++;
				words_sent++;
			end
			spof_pkg::FUNC_LOAD_SECOND: begin
				if (second_count < SEQ_MAX) begin
					second_bases[second_count] = w.base;
					second_count++;
				end
				load_words++;
				words_sent++;
			end
			spof_pkg::FUNC_RUN: begin
				res = search_overlap(w);
				overlap_q.push_back(res);
				first_count = 0;
				second_count = 0;
				run_words++;
				words_sent++;
				if (res.len != 0)
					hit_runs++;
			end
			default: ;
		endcase
	endtask

	task automatic send_word(seq_word_t w);
		in_valid <= 1'b1;
		func <= w.func;
		base <= w.base;
		first_marker <= w.first_marker;
		second_marker <= w.second_marker;
		first_support <= w.first_support;
		second_support <= w.second_support;
		first_chrom <= w.first_chrom;
		second_chrom <= w.second_chrom;
		first_is_proximal <= w.first_is_proximal;
		offset_in <= w.offset_in;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_word(w);
		if (gaps_on) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end else
				burst_left--;
		end
	endtask

	task automatic write_reg(logic [spof_pkg::REG_IDX_W-1:0] idx, int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			spof_pkg::REG_MIN_SUPPORT:
				cfg_min_support = value & ((1 << spof_pkg::MINSUP_W) - 1);
			spof_pkg::REG_MIN_OVERLAP:
				cfg_min_overlap = value & ((1 << spof_pkg::MINOV_W) - 1);
			spof_pkg::REG_MISMATCH_RATE:
				cfg_rate = value & ((1 << spof_pkg::RATE_W) - 1);
			default: ;
		endcase
	endtask

	task automatic set_search_limits(int sup, int ovl, int rate);
		write_reg(spof_pkg::REG_MIN_SUPPORT, sup);
		write_reg(spof_pkg::REG_MIN_OVERLAP, ovl);
		write_reg(spof_pkg::REG_MISMATCH_RATE, rate);
		settings_used++;
	endtask

	task automatic settle_block();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (overlap_q.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		if (overlap_q.size() != 0) begin
			$error("%0d overlap results never arrived", overlap_q.size());
			fail_count++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic seq_word_t load_word(logic [spof_pkg::FUNC_W-1:0] f,
	                                        logic [spof_pkg::BASE_W-1:0] b);
		seq_word_t w;
		logic [127:0] noise;
		noise = {$urandom, $urandom, $urandom, $urandom};
		w = noise[$bits(seq_word_t)-1:0];
		w.func = f;
		w.base = b;
		return w;
	endfunction

	function automatic seq_word_t run_word(int fm, int sm, int fs, int ss, int fc, int sc,
	                                       bit prox, int ofs);
		seq_word_t w;
		w = load_word(spof_pkg::FUNC_RUN, spof_pkg::BASE_W'($urandom));
		w.first_marker = fm[spof_pkg::MARK_W-1:0];
		w.second_marker = sm[spof_pkg::MARK_W-1:0];
		w.first_support = fs[spof_pkg::SUP_W-1:0];
		w.second_support = ss[spof_pkg::SUP_W-1:0];
		w.first_chrom = fc[spof_pkg::CHROM_W-1:0];
		w.second_chrom = sc[spof_pkg::CHROM_W-1:0];
		w.first_is_proximal = prox;
		w.offset_in = ofs[spof_pkg::OFS_W-1:0];
		return w;
	endfunction

	task automatic test_zero_overlap();
		send_word(load_word(spof_pkg::FUNC_LOAD_FIRST, 8'h00));
		send_word(load_word(spof_pkg::FUNC_LOAD_FIRST, 8'hFF));
		send_word(load_word(spof_pkg::FUNC_LOAD_SECOND, 8'hFF));
		send_word(load_word(FUNC_UNUSED, spof_pkg::BASE_W'($urandom)));
		send_word(run_word(2, 0, 0, 0, 0, 0, 1'b1, 5));
	endtask

	task automatic test_support_gate();
		settle_block();
		set_search_limits(131070, 1, 0);
		send_word(load_word(spof_pkg::FUNC_LOAD_FIRST, 8'h00));
		send_word(load_word(spof_pkg::FUNC_LOAD_FIRST, 8'hFF));
		send_word(load_word(spof_pkg::FUNC_LOAD_SECOND, 8'hFF));
		send_word(load_word(spof_pkg::FUNC_LOAD_SECOND, 8'h11));
		send_word(run_word(2, 0, 65535, 65535, 16'hFFFF, 16'hFFFF, 1'b1, 32767));
		send_word(run_word(0, 0, 65535, 65534, 0, 0, 1'b1, -32768));
		send_word(load_word(spof_pkg::FUNC_LOAD_FIRST, 8'h01));
		send_word(load_word(spof_pkg::FUNC_LOAD_SECOND, 8'h01));
		send_word(run_word(1, 0, 65535, 65535, 1, 2, 1'b1, 77));
	endtask

	task automatic test_marker_edges();
		settle_block();
		set_search_limits(0, 256, 65536);
		send_word(run_word(256, 256, 0, 0, 7, 7, 1'b0, -32768));
		send_word(run_word(0, 256, 0, 0, 7, 7, 1'b1, 100));
		settle_block();
		set_search_limits(0, 2, 65536);
		for (int i = 0; i < 3; i++) begin
			send_word(load_word(spof_pkg::FUNC_LOAD_FIRST, spof_pkg::BASE_W'(8'h10 + i)));
			send_word(load_word(spof_pkg::FUNC_LOAD_SECOND, spof_pkg::BASE_W'(8'hE0 + i)));
		end
		send_word(run_word(3, 0, 3, 4, 9, 9, 1'b1, -3));
	endtask

	task automatic test_store_full();
		logic [spof_pkg::BASE_W-1:0] b;
		settle_block();
		set_search_limits(0, 4, 0);
		for (int i = 0; i < SEQ_MAX + 2; i++) begin
			b = spof_pkg::BASE_W'($urandom);
			send_word(load_word(spof_pkg::FUNC_LOAD_FIRST, b));
			if (i < 8)
				send_word(load_word(spof_pkg::FUNC_LOAD_SECOND, b));
		end
		send_word(run_word(256, 0, $urandom, $urandom, 42, 42, 1'b1, 32700));
	endtask

	task automatic send_sequence_pair();
		logic [spof_pkg::BASE_W-1:0] prox_seq[$], dist_seq[$], first_seq[$], second_seq[$];
		logic [spof_pkg::BASE_W-1:0] alpha;
		logic [spof_pkg::CHROM_W-1:0] chrom, other_chrom;
		int lp, ld, k, mp, md, ofs;
		bit prox_first;
		alpha = spof_pkg::BASE_W'($urandom);
		lp = $urandom_range(0, 12);
		ld = $urandom_range(0, 12);
		for (int i = 0; i < lp; i++)
			prox_seq.push_back(alpha ^ spof_pkg::BASE_W'($urandom_range(0, 3)));
		k = $urandom_range(0, lp < ld ? lp : ld);
		for (int i = 0; i < ld; i++)
			if (i < k && $urandom_range(0, 7) != 0)
				dist_seq.push_back(prox_seq[lp - k + i]);
			else
				dist_seq.push_back(alpha ^ spof_pkg::BASE_W'($urandom_range(0, 3)));
		prox_first = 1'($urandom);
		if (prox_first) begin
			first_seq = prox_seq;
			second_seq = dist_seq;
		end else begin
			first_seq = dist_seq;
			second_seq = prox_seq;
		end
		while (first_seq.size() + second_seq.size() != 0) begin
			if ($urandom_range(0, 9) == 0)
				send_word(load_word(FUNC_UNUSED, spof_pkg::BASE_W'($urandom)));
			if ($urandom_range(0, 39) == 0)
				send_word(run_word($urandom_range(0, 16), $urandom_range(0, 16), $urandom,
					$urandom, 5, 5, 1'($urandom), $urandom));
			if (second_seq.size() == 0 || (first_seq.size() != 0 && $urandom_range(0, 1)))
				send_word(load_word(spof_pkg::FUNC_LOAD_FIRST, first_seq.pop_front()));
			else
				send_word(load_word(spof_pkg::FUNC_LOAD_SECOND, second_seq.pop_front()));
		end
		if ($urandom_range(0, 15) == 0)
			mp = $urandom_range(0, SEQ_MAX);
		else if ($urandom_range(0, 1))
			mp = lp;
		else
			mp = $urandom_range(0, lp + 3);
		if ($urandom_range(0, 7) == 0)
			md = $urandom_range(0, SEQ_MAX);
		else
			md = $urandom_range(0, mp);
		case ($urandom_range(0, 3))
			0: ofs = 32767 - $urandom_range(0, 4);
			1: ofs = -32768 + $urandom_range(0, 4);
			default: ofs = $urandom;
		endcase
		chrom = spof_pkg::CHROM_W'($urandom);
		other_chrom = chrom;
		if ($urandom_range(0, 7) == 0)
			other_chrom = chrom ^ (16'h1 << $urandom_range(0, 15));
		send_word(run_word(prox_first ? mp : md, prox_first ? md : mp, $urandom, $urandom,
			int'(chrom), int'(other_chrom), prox_first, ofs));
	endtask

	task automatic test_random_mix();
		int goal;
		for (int phase = 0; phase < 6; phase++) begin
			settle_block();
			case (phase)
				0: set_search_limits(0, 0, 0);
				1: set_search_limits($urandom_range(0, 70000), 2, 6554);
				2: set_search_limits(0, 3, 65536);
				3: set_search_limits($urandom_range(0, 131070), $urandom_range(0, 6),
					$urandom_range(0, 65536));
				4: set_search_limits(0, 256, 0);
				default: set_search_limits(1, 1, 21845);
			endcase
			gaps_on = (phase != 3);
			if (phase == 2)
				hold_asked++;
			goal = words_sent + 40;
			while (words_sent < goal)
				send_sequence_pair();
		end
	endtask

	// receiver: patterned stalls, plus a long hold on request
	initial begin
		int hold_left, tick;
		out_ready = 1'b0;
		hold_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case ((tick / 300) % 4)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (tick % 7 < 4);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		overlap_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (overlap_q.size() == 0) begin
				$error("unexpected overlap result: len %0d offset %0d",
					overlap_len, $signed(offset_out));
				fail_count++;
			end else begin
				exp_r = overlap_q.pop_front();
				if (overlap_len !== exp_r.len) begin
					$error("overlap_len: expected %0d, got %0d", exp_r.len, overlap_len);
					fail_count++;
				end
				if (offset_out !== exp_r.ofs) begin
					$error("offset_out: expected %0d, got %0d",
						$signed(exp_r.ofs), $signed(offset_out));
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		func = '0;
		base = '0;
		first_marker = '0;
		second_marker = '0;
		first_support = '0;
		second_support = '0;
		first_chrom = '0;
		second_chrom = '0;
		first_is_proximal = 1'b0;
		offset_in = '0;
		first_count = 0;
		second_count = 0;
		cfg_min_support = 0;
		cfg_min_overlap = 0;
		cfg_rate = 0;
		fail_count = 0;
		words_sent = 0;
		load_words = 0;
		run_words = 0;
		hit_runs = 0;
		settings_used = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		hold_asked = 0;
		hold_served = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_zero_overlap();
		test_support_gate();
		test_marker_edges();
		test_store_full();
		test_random_mix();
		settle_block();
		$display("Sent %0d load words and %0d search runs (%0d with a nonzero overlap)",
			load_words, run_words, hit_runs);
		$display("under %0d register settings, with an overfilled store and a long output hold.",
			settings_used);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
